/* rtl/apef_pkg.sv */
// Shared types and constants of the audio peak envelope follower.
`timescale 1ns / 1ps
`default_nettype none

package apef_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned FloorW    = 15;
  localparam int unsigned GainW     = 16;
  localparam int unsigned RatioW    = 17;
  localparam int unsigned LevelW    = 16;
  localparam int unsigned EnvW      = 32;
  localparam int unsigned AluW      = 33;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned DivSteps  = 16;
  localparam int unsigned CountW    = 4;

  localparam logic [CfgIndexW-1:0] RegNoiseFloor     = 3'd0;
  localparam logic [CfgIndexW-1:0] RegFollowerMinimum = 3'd1;
  localparam logic [CfgIndexW-1:0] RegAttackGain     = 3'd2;
  localparam logic [CfgIndexW-1:0] RegDecayGain      = 3'd3;
  localparam logic [CfgIndexW-1:0] RegSmoothingGain  = 3'd4;

  localparam logic [FloorW-1:0] NoiseFloorReset     = 15'd750;
  localparam logic [FloorW-1:0] FollowerMinimumReset = 15'd750;
  localparam logic [GainW-1:0]  AttackGainReset     = 16'd45613;
  localparam logic [GainW-1:0]  DecayGainReset      = 16'd5237;
  localparam logic [GainW-1:0]  SmoothingGainReset  = 16'd19912;
  localparam logic [EnvW-1:0]   EnvReset            = 32'd49152000;
  localparam logic [RatioW-1:0] RatioOne            = 17'd65536;

  typedef enum logic [2:0] {
    ALU_DIFF,
    ALU_SCALE,
    ALU_MOVE,
    ALU_DIVSTEP
  } alu_op_t;

  typedef enum logic [2:0] {
    A_PEAK,
    A_TARGET,
    A_ACC,
    A_ENV,
    A_MIN,
    A_REM2,
    A_RATIO,
    A_SMOOTH
  } a_sel_t;

  typedef enum logic [2:0] {
    B_FLOOR,
    B_ENV,
    B_TARGET,
    B_ACC,
    B_SMOOTH
  } b_sel_t;

  typedef enum logic {
    G_ENV,
    G_SMOOTH
  } g_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FLOOR,
    S_ENV_DIFF,
    S_ENV_SCALE,
    S_ENV_STEP,
    S_ENV_CLAMP,
    S_DIV_INIT,
    S_DIV,
    S_SM_DIFF,
    S_SM_SCALE,
    S_SM_STEP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    ready;
    alu_op_t op;
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    g_sel_t  g_sel;
    logic    ld_p;
    logic    ld_diff;
    logic    ld_acc;
    logic    ld_env;
    logic    clamp;
    logic    div_init;
    logic    div_step;
    logic    ld_smooth;
    logic    ld_out;
  } ctrl_t;

endpackage

`default_nettype wire

/* rtl/apef_if.sv */
// Valid/ready channel interfaces for samples and frame results.
`timescale 1ns / 1ps
`default_nettype none

interface apef_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [apef_pkg::SampleW-1:0] sample;
  logic                                frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink (input valid, input sample, input frame_end, output ready);
endinterface

interface apef_result_if;
  logic                         valid;
  logic                         ready;
  logic [apef_pkg::RatioW-1:0]  peak_ratio;
  logic [apef_pkg::RatioW-1:0]  peak_ratio_smoothed;
  logic [apef_pkg::LevelW-1:0]  follower_level;

  modport source (output valid, output peak_ratio, output peak_ratio_smoothed,
                  output follower_level, input ready);
  modport sink (input valid, input peak_ratio, input peak_ratio_smoothed,
                input follower_level, output ready);
endinterface

`default_nettype wire

/* rtl/audio_peak_envelope_follower.sv */
// Top level of the audio peak envelope follower.
`timescale 1ns / 1ps
`default_nettype none

// Tracks the largest sample magnitude of each frame and, on the sample that
// ends a frame, updates an attack/decay follower, divides the floor-reduced
// peak by it (saturated at 1.0, Q1.16) and smooths that ratio, giving one
// result per frame. Samples that do not end a frame transfer one per cycle while the block is idle.
// A frame-end sample holds off the next sample while the block runs the floor,
// follower, divide and smoothing steps (the divide is skipped when the ratio
// saturates), plus any wait for the result register to drain: all steps share
// one arithmetic unit, and the restoring divide in it retires one quotient bit per cycle.
module audio_peak_envelope_follower (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [apef_pkg::CfgIndexW-1:0]   cfg_index,
  input  wire logic [apef_pkg::CfgDataW-1:0]    cfg_data,
  apef_sample_if.sink                           samples,
  apef_result_if.source                         results
);

  apef_pkg::ctrl_t                     ctl;

  logic [apef_pkg::FloorW-1:0]         noise_floor;
  logic [apef_pkg::FloorW-1:0]         follower_minimum;
  logic [apef_pkg::GainW-1:0]          attack_gain;
  logic [apef_pkg::GainW-1:0]          decay_gain;
  logic [apef_pkg::GainW-1:0]          smoothing_gain;

  logic [apef_pkg::SampleW-1:0]        peak;
  logic [apef_pkg::SampleW-1:0]        mag;
  logic [apef_pkg::SampleW-1:0]        peak_next;
  logic [apef_pkg::SampleW-1:0]        p;
  logic [apef_pkg::EnvW-1:0]           target;
  logic [apef_pkg::EnvW-1:0]           env;
  logic [apef_pkg::EnvW-1:0]           acc;
  logic                                dir;
  logic [apef_pkg::EnvW-1:0]           rem;
  logic [apef_pkg::RatioW-1:0]         ratio;
  logic [apef_pkg::RatioW-1:0]         smooth;
  logic [apef_pkg::FloorW-1:0]         min_level;
  logic [apef_pkg::EnvW-1:0]           min_q;

  logic [apef_pkg::AluW-1:0]           alu_a;
  logic [apef_pkg::AluW-1:0]           alu_b;
  logic [apef_pkg::GainW-1:0]          alu_gain;
  logic [apef_pkg::AluW-1:0]           alu_res;
  logic                                alu_flag;

  logic                                accept;
  logic                                start;
  logic                                out_free;

  logic                                out_valid;
  logic [apef_pkg::RatioW-1:0]         out_ratio;
  logic [apef_pkg::RatioW-1:0]         out_smooth;
  logic [apef_pkg::LevelW-1:0]         out_level;

  assign samples.ready = ctl.ready;
  assign accept        = samples.valid && samples.ready;
  assign start         = accept && samples.frame_end;
  assign out_free      = !out_valid || results.ready;

  assign mag       = samples.sample[apef_pkg::SampleW-1] ?
                     apef_pkg::SampleW'(-samples.sample) : samples.sample;
  assign peak_next = (mag > peak) ? mag : peak;

  assign target    = {p, 16'd0};
  assign min_level = (follower_minimum == '0) ? apef_pkg::FloorW'(1) : follower_minimum;
  assign min_q     = {1'b0, min_level, 16'd0};

  always_comb begin
    unique case (ctl.a_sel)
      apef_pkg::A_PEAK:   alu_a = {17'd0, peak};
      apef_pkg::A_TARGET: alu_a = {1'b0, target};
      apef_pkg::A_ACC:    alu_a = {1'b0, acc};
      apef_pkg::A_ENV:    alu_a = {1'b0, env};
      apef_pkg::A_MIN:    alu_a = {1'b0, min_q};
      apef_pkg::A_REM2:   alu_a = {rem, 1'b0};
      apef_pkg::A_RATIO:  alu_a = {16'd0, ratio};
      apef_pkg::A_SMOOTH: alu_a = {16'd0, smooth};
      default:            alu_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.b_sel)
      apef_pkg::B_FLOOR:  alu_b = {18'd0, noise_floor};
      apef_pkg::B_ENV:    alu_b = {1'b0, env};
      apef_pkg::B_TARGET: alu_b = {1'b0, target};
      apef_pkg::B_ACC:    alu_b = {1'b0, acc};
      apef_pkg::B_SMOOTH: alu_b = {16'd0, smooth};
      default:            alu_b = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.g_sel)
      apef_pkg::G_ENV:    alu_gain = dir ? attack_gain : decay_gain;
      apef_pkg::G_SMOOTH: alu_gain = smoothing_gain;
      default:            alu_gain = smoothing_gain;
    endcase
  end

  apef_alu u_alu (
    .op   (ctl.op),
    .a    (alu_a),
    .b    (alu_b),
    .gain (alu_gain),
    .dir  (dir),
    .res  (alu_res),
    .flag (alu_flag)
  );

  apef_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .flag     (alu_flag),
    .out_free (out_free),
    .ctl      (ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_floor      <= apef_pkg::NoiseFloorReset;
      follower_minimum <= apef_pkg::FollowerMinimumReset;
      attack_gain      <= apef_pkg::AttackGainReset;
      decay_gain       <= apef_pkg::DecayGainReset;
      smoothing_gain   <= apef_pkg::SmoothingGainReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        apef_pkg::RegNoiseFloor:      noise_floor      <= cfg_data[apef_pkg::FloorW-1:0];
        apef_pkg::RegFollowerMinimum: follower_minimum <= cfg_data[apef_pkg::FloorW-1:0];
        apef_pkg::RegAttackGain:      attack_gain      <= cfg_data;
        apef_pkg::RegDecayGain:       decay_gain       <= cfg_data;
        apef_pkg::RegSmoothingGain:   smoothing_gain   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak   <= '0;
      env    <= apef_pkg::EnvReset;
      smooth <= '0;
    end else begin
      if (accept) begin
        peak <= peak_next;
      end else if (ctl.ld_p) begin
        peak <= '0;
      end
      if (ctl.ld_env) begin
        env <= alu_res[apef_pkg::EnvW-1:0];
      end else if (ctl.clamp && alu_flag) begin
        env <= min_q;
      end
      if (ctl.ld_smooth) begin
        smooth <= alu_res[apef_pkg::RatioW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_p) begin
      p <= alu_flag ? alu_res[apef_pkg::SampleW-1:0] : '0;
    end
    if (ctl.ld_diff) begin
      acc <= alu_res[apef_pkg::EnvW-1:0];
      dir <= alu_flag;
    end else if (ctl.ld_acc) begin
      acc <= alu_res[apef_pkg::EnvW-1:0];
    end
    if (ctl.div_init) begin
      rem   <= target;
      ratio <= alu_flag ? '0 : apef_pkg::RatioOne;
    end else if (ctl.div_step) begin
      rem   <= alu_res[apef_pkg::EnvW-1:0];
      ratio <= {ratio[apef_pkg::RatioW-2:0], alu_flag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.ld_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      out_ratio  <= ratio;
      out_smooth <= smooth;
      out_level  <= env[apef_pkg::EnvW-1:apef_pkg::EnvW-apef_pkg::LevelW];
    end
  end

  assign results.valid               = out_valid;
  assign results.peak_ratio          = out_ratio;
  assign results.peak_ratio_smoothed = out_smooth;
  assign results.follower_level      = out_level;

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.ld_out |=> results.valid)
    else $error("result load did not raise valid");

  a_level_floor: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.follower_level != '0)
    else $error("follower level below one");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.peak_ratio <= apef_pkg::RatioOne) &&
                      (results.peak_ratio_smoothed <= apef_pkg::RatioOne))
    else $error("ratio above 1.0");

  a_busy_divide: assert property (@(posedge clk) disable iff (rst)
    ctl.div_step |-> !samples.ready)
    else $error("sample transfer allowed during divide");

endmodule

`default_nettype wire

/* rtl/apef_alu.sv */
// Shared arithmetic unit: difference, gain scaling, step and divide step.
`timescale 1ns / 1ps
`default_nettype none

module apef_alu (
  input  wire apef_pkg::alu_op_t         op,
  input  wire logic [apef_pkg::AluW-1:0] a,
  input  wire logic [apef_pkg::AluW-1:0] b,
  input  wire logic [apef_pkg::GainW-1:0] gain,
  input  wire logic                      dir,
  output logic      [apef_pkg::AluW-1:0] res,
  output logic                           flag
);

  logic [apef_pkg::EnvW+apef_pkg::GainW-1:0] prod;

  always_comb begin
    prod = a[apef_pkg::EnvW-1:0] * gain;
    res  = '0;
    flag = 1'b0;
    unique case (op)
      apef_pkg::ALU_DIFF: begin
        flag = a > b;
        res  = flag ? (a - b) : (b - a);
      end
      apef_pkg::ALU_SCALE: begin
        res = {1'b0, prod[apef_pkg::EnvW+apef_pkg::GainW-1:apef_pkg::GainW]};
      end
      apef_pkg::ALU_MOVE: begin
        res = dir ? (a + b) : (a - b);
      end
      apef_pkg::ALU_DIVSTEP: begin
        flag = a >= b;
        res  = flag ? (a - b) : a;
      end
      default: begin
        res  = '0;
        flag = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/apef_ctrl.sv */
// Sequencer that steps the shared unit through one frame-end update.
`timescale 1ns / 1ps
`default_nettype none

module apef_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            flag,
  input  wire logic            out_free,
  output apef_pkg::ctrl_t      ctl
);

  apef_pkg::state_t                   state;
  apef_pkg::state_t                   state_next;
  logic [apef_pkg::CountW-1:0]        cnt;
  logic                               cnt_last;

  assign cnt_last = (cnt == apef_pkg::CountW'(apef_pkg::DivSteps - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apef_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == apef_pkg::S_DIV_INIT) begin
        cnt <= '0;
      end else if (state == apef_pkg::S_DIV) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      apef_pkg::S_IDLE:      if (start) state_next = apef_pkg::S_FLOOR;
      apef_pkg::S_FLOOR:     state_next = apef_pkg::S_ENV_DIFF;
      apef_pkg::S_ENV_DIFF:  state_next = apef_pkg::S_ENV_SCALE;
      apef_pkg::S_ENV_SCALE: state_next = apef_pkg::S_ENV_STEP;
      apef_pkg::S_ENV_STEP:  state_next = apef_pkg::S_ENV_CLAMP;
      apef_pkg::S_ENV_CLAMP: state_next = apef_pkg::S_DIV_INIT;
      apef_pkg::S_DIV_INIT:  state_next = flag ? apef_pkg::S_DIV : apef_pkg::S_SM_DIFF;
      apef_pkg::S_DIV:       if (cnt_last) state_next = apef_pkg::S_SM_DIFF;
      apef_pkg::S_SM_DIFF:   state_next = apef_pkg::S_SM_SCALE;
      apef_pkg::S_SM_SCALE:  state_next = apef_pkg::S_SM_STEP;
      apef_pkg::S_SM_STEP:   state_next = apef_pkg::S_OUT;
      apef_pkg::S_OUT:       if (out_free) state_next = apef_pkg::S_IDLE;
      default:               state_next = apef_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl.ready     = 1'b0;
    ctl.op        = apef_pkg::ALU_DIFF;
    ctl.a_sel     = apef_pkg::A_PEAK;
    ctl.b_sel     = apef_pkg::B_FLOOR;
    ctl.g_sel     = apef_pkg::G_ENV;
    ctl.ld_p      = 1'b0;
    ctl.ld_diff   = 1'b0;
    ctl.ld_acc    = 1'b0;
    ctl.ld_env    = 1'b0;
    ctl.clamp     = 1'b0;
    ctl.div_init  = 1'b0;
    ctl.div_step  = 1'b0;
    ctl.ld_smooth = 1'b0;
    ctl.ld_out    = 1'b0;
    unique case (state)
      apef_pkg::S_IDLE: begin
        ctl.ready = 1'b1;
      end
      apef_pkg::S_FLOOR: begin
        ctl.ld_p = 1'b1;
      end
      apef_pkg::S_ENV_DIFF: begin
        ctl.a_sel   = apef_pkg::A_TARGET;
        ctl.b_sel   = apef_pkg::B_ENV;
        ctl.ld_diff = 1'b1;
      end
      apef_pkg::S_ENV_SCALE: begin
        ctl.op     = apef_pkg::ALU_SCALE;
        ctl.a_sel  = apef_pkg::A_ACC;
        ctl.g_sel  = apef_pkg::G_ENV;
        ctl.ld_acc = 1'b1;
      end
      apef_pkg::S_ENV_STEP: begin
        ctl.op     = apef_pkg::ALU_MOVE;
        ctl.a_sel  = apef_pkg::A_ENV;
        ctl.b_sel  = apef_pkg::B_ACC;
        ctl.ld_env = 1'b1;
      end
      apef_pkg::S_ENV_CLAMP: begin
        ctl.a_sel = apef_pkg::A_MIN;
        ctl.b_sel = apef_pkg::B_ENV;
        ctl.clamp = 1'b1;
      end
      apef_pkg::S_DIV_INIT: begin
        ctl.a_sel    = apef_pkg::A_ENV;
        ctl.b_sel    = apef_pkg::B_TARGET;
        ctl.div_init = 1'b1;
      end
      apef_pkg::S_DIV: begin
        ctl.op       = apef_pkg::ALU_DIVSTEP;
        ctl.a_sel    = apef_pkg::A_REM2;
        ctl.b_sel    = apef_pkg::B_ENV;
        ctl.div_step = 1'b1;
      end
      apef_pkg::S_SM_DIFF: begin
        ctl.a_sel   = apef_pkg::A_RATIO;
        ctl.b_sel   = apef_pkg::B_SMOOTH;
        ctl.ld_diff = 1'b1;
      end
      apef_pkg::S_SM_SCALE: begin
        ctl.op     = apef_pkg::ALU_SCALE;
        ctl.a_sel  = apef_pkg::A_ACC;
        ctl.g_sel  = apef_pkg::G_SMOOTH;
        ctl.ld_acc = 1'b1;
      end
      apef_pkg::S_SM_STEP: begin
        ctl.op        = apef_pkg::ALU_MOVE;
        ctl.a_sel     = apef_pkg::A_SMOOTH;
        ctl.b_sel     = apef_pkg::B_ACC;
        ctl.ld_smooth = 1'b1;
      end
      apef_pkg::S_OUT: begin
        ctl.ld_out = out_free;
      end
      default: begin
        ctl.ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire
